@@ src/isc_pkg.sv @@
`timescale 1ns / 1ps
// Shared codes and types for the overlap success counter block.
// No dependencies; imported by the top level and its checker.
package isc_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;

   // Operation codes carried by the op field of a request transaction.
   localparam op_type OP_ADD_FRAME = 2'd0;
   localparam op_type OP_READ_STEP = 2'd1;
   localparam op_type OP_CLEAR     = 2'd2;

   // Status codes returned with every response transaction.
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_ZERO_UNION = 2'd1;
   localparam status_type STATUS_BAD_STEP   = 2'd2;

   // Threshold step count after reset.
   localparam logic [7:0] STEPS_RESET = 8'd100;

endpackage

@@ src/isc_mul.sv @@
`timescale 1ns / 1ps
// Shared registered multiplier used for all area and threshold products.
// No package dependencies.
module isc_mul #(
   parameter int A_BITS = 24,
   parameter int B_BITS = 12
) (
   input  logic                       clock,
   input  logic [A_BITS-1:0]          op_a,
   input  logic [B_BITS-1:0]          op_b,
   output logic [A_BITS+B_BITS-1:0]   product
);

   logic [A_BITS+B_BITS-1:0] prod_ff;
   logic [A_BITS+B_BITS-1:0] prod_in;

   assign prod_in = (A_BITS + B_BITS)'(op_a) * (A_BITS + B_BITS)'(op_b);

   // The product is registered and ready in the cycle after the operands are presented.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

@@ src/isc_cnt_ram.sv @@
`timescale 1ns / 1ps
// Per-step success counter memory: one write port, one registered read port.
// No package dependencies.
module isc_cnt_ram #(
   parameter int DEPTH     = 128,
   parameter int ADDR_BITS = 7,
   parameter int DATA_BITS = 20
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/iou_success_curve.sv @@
`timescale 1ns / 1ps
// Top level of the overlap success counter block: sequencer, configuration and output register.
// Depends on isc_pkg, isc_mul and isc_cnt_ram.

// Each request transaction is one of three operations. An add-frame transaction
// intersects a tracked box with a ground-truth box, computes the union area and
// bumps the saturating success counter of every threshold step s (0 <= s < steps)
// for which inter*steps >= s*union, then bumps the frame counter; a frame whose
// union area is zero returns status 1 and changes nothing. A read transaction
// returns the counter of one step with the frame count, and a clear transaction
// zeroes all counters. Exactly one response transaction follows each request.
// The block works on one transaction at a time and holds req_stall high while
// busy. All products go through one shared registered multiplier (intersection,
// both box areas, then inter*steps), after which the step sweep walks the counter
// memory one step per cycle with a running sum of union, doing a read-modify-write
// of each passing counter; the sweep stops at the first failing step. An add-frame
// goes from acceptance through S_GEOM, S_MUL_I/T/G/S, S_LHS and S_SWEEP to the
// S_FINISH state that loads its response (a zero-union frame skips S_SWEEP); a
// read goes through S_READ, and unused op 3 and a read of a step that does not
// exist go straight to S_FINISH. The counter memory has one write port, so a
// clear sweeps it one entry per cycle. The same sweep runs after reset, and
// requests stall until it ends. S_FINISH waits while a response is stalled.
// The threshold step count register may be written at any time the block is idle;
// values of zero act as one and values above MAX_STEPS act as MAX_STEPS.
module iou_success_curve
   import isc_pkg::*;
#(
   parameter int MAX_STEPS  = 128,
   parameter int COORD_BITS = 12,
   parameter int COUNT_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [COORD_BITS-1:0] req_track_x,
   input  logic [COORD_BITS-1:0] req_track_y,
   input  logic [COORD_BITS-1:0] req_track_w,
   input  logic [COORD_BITS-1:0] req_track_h,
   input  logic [COORD_BITS-1:0] req_truth_x,
   input  logic [COORD_BITS-1:0] req_truth_y,
   input  logic [COORD_BITS-1:0] req_truth_w,
   input  logic [COORD_BITS-1:0] req_truth_h,
   input  logic [6:0]            req_step_index,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [COUNT_BITS-1:0] rsp_success_count,
   output logic [COUNT_BITS-1:0] rsp_frame_count,
   output logic [7:0]            rsp_passed_steps
);

   localparam int C         = COORD_BITS;
   localparam int ADDR_BITS = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int STEP_CAP  = (MAX_STEPS < 255) ? MAX_STEPS : 255;
   localparam int AREA_BITS = 2 * C;
   localparam int PROD_BITS = 3 * C;
   localparam int UNI_BITS  = 2 * C + 1;
   localparam int ACC_BITS  = 3 * C + 1;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(MAX_STEPS - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_GEOM   = 4'd1;
   localparam logic [3:0] S_MUL_I  = 4'd2;
   localparam logic [3:0] S_MUL_T  = 4'd3;
   localparam logic [3:0] S_MUL_G  = 4'd4;
   localparam logic [3:0] S_MUL_S  = 4'd5;
   localparam logic [3:0] S_LHS    = 4'd6;
   localparam logic [3:0] S_SWEEP  = 4'd7;
   localparam logic [3:0] S_READ   = 4'd8;
   localparam logic [3:0] S_CLEAR  = 4'd9;
   localparam logic [3:0] S_INIT   = 4'd10;
   localparam logic [3:0] S_FINISH = 4'd11;

   // Control state.
   logic [3:0]            state_ff, state_in;
   logic [7:0]            thr_ff, thr_in;
   logic [COUNT_BITS-1:0] frames_ff, frames_in;
   logic [ADDR_BITS-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [C-1:0]          tx_ff, ty_ff, tw_ff, th_ff, tx_in, ty_in, tw_in, th_in;
   logic [C-1:0]          gx_ff, gy_ff, gw_ff, gh_ff, gx_in, gy_in, gw_in, gh_in;
   logic [C-1:0]          ow_ff, oh_ff, ow_in, oh_in;
   logic [AREA_BITS-1:0]  inter_ff, inter_in, area_ff, area_in;
   logic [UNI_BITS-1:0]   union_ff, union_in;
   logic [PROD_BITS-1:0]  lhs_ff, lhs_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [7:0]            step_ff, step_in;
   logic [ADDR_BITS-1:0]  wr_addr_ff, wr_addr_in;
   logic [1:0]            status_ff, status_in;
   logic [COUNT_BITS-1:0] succ_ff, succ_in;
   logic [7:0]            passed_ff, passed_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0] rsp_succ_ff, rsp_succ_in;
   logic [COUNT_BITS-1:0] rsp_frames_ff, rsp_frames_in;
   logic [7:0]            rsp_passed_ff, rsp_passed_in;

   // Shared multiplier and counter memory connections.
   logic [AREA_BITS-1:0]  mul_a;
   logic [C-1:0]          mul_b;
   logic [PROD_BITS-1:0]  mul_p;
   logic                  ram_rd_en;
   logic [ADDR_BITS-1:0]  ram_rd_addr;
   logic [COUNT_BITS-1:0] ram_rd_data;
   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;

   // Overlap geometry.
   logic [C:0]            tx_end, gx_end, ty_end, gy_end, hi_x, hi_y;
   logic [C-1:0]          lo_x, lo_y;

   logic [7:0]            steps_eff;
   logic                  req_take;
   logic                  rsp_free;
   logic                  step_pass;

   // Steps in effect: the register clamped to the range one to MAX_STEPS.
   always_comb begin
      if (thr_ff == 8'd0) begin
         steps_eff = 8'd1;
      end else if (thr_ff > 8'(STEP_CAP)) begin
         steps_eff = 8'(STEP_CAP);
      end else begin
         steps_eff = thr_ff;
      end
   end

   // Edge sums are one bit wider so that boxes past the frame edge stay exact.
   always_comb begin
      tx_end = {1'b0, tx_ff} + {1'b0, tw_ff};
      gx_end = {1'b0, gx_ff} + {1'b0, gw_ff};
      ty_end = {1'b0, ty_ff} + {1'b0, th_ff};
      gy_end = {1'b0, gy_ff} + {1'b0, gh_ff};
      lo_x   = (tx_ff > gx_ff) ? tx_ff : gx_ff;
      lo_y   = (ty_ff > gy_ff) ? ty_ff : gy_ff;
      hi_x   = (tx_end < gx_end) ? tx_end : gx_end;
      hi_y   = (ty_end < gy_end) ? ty_end : gy_end;
      ow_in  = (hi_x > {1'b0, lo_x}) ? C'(hi_x - {1'b0, lo_x}) : '0;
      oh_in  = (hi_y > {1'b0, lo_y}) ? C'(hi_y - {1'b0, lo_y}) : '0;
   end

   // Operand selection for the shared multiplier, one product per sequencer state.
   always_comb begin
      case (state_ff)
         S_MUL_I: begin
            mul_a = AREA_BITS'(ow_ff);
            mul_b = oh_ff;
         end
         S_MUL_T: begin
            mul_a = AREA_BITS'(tw_ff);
            mul_b = th_ff;
         end
         S_MUL_G: begin
            mul_a = AREA_BITS'(gw_ff);
            mul_b = gh_ff;
         end
         S_MUL_S: begin
            mul_a = inter_ff;
            mul_b = C'(steps_eff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   isc_mul #(
      .A_BITS (AREA_BITS),
      .B_BITS (C)
   ) u_isc_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // The running sum acc_ff holds step_ff * union; passing steps are a prefix.
   assign step_pass = (state_ff == S_SWEEP) && (step_ff < steps_eff) &&
                      (ACC_BITS'(lhs_ff) >= acc_ff);

   // Counter memory ports. A passing step is read here and written back
   // incremented on the following cycle, so the sweep retires one step a cycle.
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = ADDR_BITS'(step_ff);
      if (req_take && (req_op == OP_READ_STEP)) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = ADDR_BITS'(req_step_index);
      end else if (step_pass) begin
         ram_rd_en   = 1'b1;
      end

      if ((state_ff == S_CLEAR) || (state_ff == S_INIT)) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = wr_pend_ff;
         ram_wr_addr = wr_addr_ff;
         ram_wr_data = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + COUNT_BITS'(1);
      end
   end

   isc_cnt_ram #(
      .DEPTH     (MAX_STEPS),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (COUNT_BITS)
   ) u_isc_cnt_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      thr_in        = csr_wr_en ? csr_wr_data : thr_ff;
      frames_in     = frames_ff;
      clr_cnt_in    = clr_cnt_ff;
      wr_pend_in    = step_pass;
      wr_addr_in    = ADDR_BITS'(step_ff);
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      tx_in = tx_ff; ty_in = ty_ff; tw_in = tw_ff; th_in = th_ff;
      gx_in = gx_ff; gy_in = gy_ff; gw_in = gw_ff; gh_in = gh_ff;
      inter_in      = inter_ff;
      area_in       = area_ff;
      union_in      = union_ff;
      lhs_in        = lhs_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      status_in     = status_ff;
      succ_in       = succ_ff;
      passed_in     = passed_ff;
      rsp_status_in = rsp_status_ff;
      rsp_succ_in   = rsp_succ_ff;
      rsp_frames_in = rsp_frames_ff;
      rsp_passed_in = rsp_passed_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               status_in = STATUS_OK;
               succ_in   = '0;
               passed_in = '0;
               case (req_op)
                  OP_ADD_FRAME: begin
                     tx_in = req_track_x; ty_in = req_track_y;
                     tw_in = req_track_w; th_in = req_track_h;
                     gx_in = req_truth_x; gy_in = req_truth_y;
                     gw_in = req_truth_w; gh_in = req_truth_h;
                     state_in = S_GEOM;
                  end
                  OP_READ_STEP: begin
                     if ({1'b0, req_step_index} < steps_eff) begin
                        state_in = S_READ;
                     end else begin
                        status_in = STATUS_BAD_STEP;
                        state_in  = S_FINISH;
                     end
                  end
                  OP_CLEAR: begin
                     frames_in  = '0;
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_GEOM: begin
            state_in = S_MUL_I;
         end
         S_MUL_I: begin
            state_in = S_MUL_T;
         end
         S_MUL_T: begin
            inter_in = mul_p[AREA_BITS-1:0];
            state_in = S_MUL_G;
         end
         S_MUL_G: begin
            area_in  = mul_p[AREA_BITS-1:0];
            state_in = S_MUL_S;
         end
         S_MUL_S: begin
            // Each box area is at least the intersection, so this never wraps.
            union_in = UNI_BITS'(area_ff) + UNI_BITS'(mul_p[AREA_BITS-1:0]) -
                       UNI_BITS'(inter_ff);
            state_in = S_LHS;
         end
         S_LHS: begin
            lhs_in  = mul_p;
            acc_in  = '0;
            step_in = '0;
            if (union_ff == '0) begin
               status_in = STATUS_ZERO_UNION;
               state_in  = S_FINISH;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (step_pass) begin
               step_in = step_ff + 8'd1;
               acc_in  = acc_ff + ACC_BITS'(union_ff);
            end else begin
               passed_in = step_ff;
               frames_in = (frames_ff == '1) ? frames_ff : frames_ff + COUNT_BITS'(1);
               state_in  = S_FINISH;
            end
         end
         S_READ: begin
            succ_in  = ram_rd_data;
            state_in = S_FINISH;
         end
         S_CLEAR, S_INIT: begin
            clr_cnt_in = clr_cnt_ff + ADDR_BITS'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = (state_ff == S_CLEAR) ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_succ_in   = succ_ff;
               rsp_frames_in = frames_ff;
               rsp_passed_in = passed_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         thr_ff       <= STEPS_RESET;
         frames_ff    <= '0;
         clr_cnt_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         frames_ff    <= frames_in;
         clr_cnt_ff   <= clr_cnt_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff <= tx_in; ty_ff <= ty_in; tw_ff <= tw_in; th_ff <= th_in;
      gx_ff <= gx_in; gy_ff <= gy_in; gw_ff <= gw_in; gh_ff <= gh_in;
      ow_ff         <= ow_in;
      oh_ff         <= oh_in;
      inter_ff      <= inter_in;
      area_ff       <= area_in;
      union_ff      <= union_in;
      lhs_ff        <= lhs_in;
      acc_ff        <= acc_in;
      step_ff       <= step_in;
      wr_addr_ff    <= wr_addr_in;
      status_ff     <= status_in;
      succ_ff       <= succ_in;
      passed_ff     <= passed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_succ_ff   <= rsp_succ_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_passed_ff <= rsp_passed_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_success_count = rsp_succ_ff;
   assign rsp_frame_count   = rsp_frames_ff;
   assign rsp_passed_steps  = rsp_passed_ff;

endmodule

@@ src/isc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the overlap success counter block, and its bind.
// Depends on isc_pkg and the iou_success_curve top level.
module isc_checker
   import isc_pkg::*;
#(
   parameter int COUNT_BITS = 20
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [1:0]            rsp_status,
   input logic [COUNT_BITS-1:0] rsp_success_count,
   input logic [COUNT_BITS-1:0] rsp_frame_count,
   input logic [7:0]            rsp_passed_steps
);

   // The counter memory is cleared after reset before any transaction is taken.
   a_init_stall: assert property (@(posedge clock) $fell(reset) |-> req_stall)
      else $error("request taken during the post-reset clearing pass");

   // One transaction at a time: the block is busy right after accepting one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transaction could be accepted back to back");

   // A zero-union frame counts nothing.
   a_zero_union: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_ZERO_UNION)) |->
      (rsp_passed_steps == 8'd0) && (rsp_success_count == '0))
      else $error("zero-union response reports counts");

   // Only a successful frame reports passed steps, and it carries no step count.
   a_passed_only_add: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_passed_steps != 8'd0)) |->
      (rsp_status == STATUS_OK) && (rsp_success_count == '0))
      else $error("passed steps reported on a non-frame response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_success_count) && $stable(rsp_frame_count) &&
      $stable(rsp_passed_steps))
      else $error("stalled response changed");

endmodule

bind iou_success_curve isc_checker #(
   .COUNT_BITS (COUNT_BITS)
) u_isc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_success_count (rsp_success_count),
   .rsp_frame_count   (rsp_frame_count),
   .rsp_passed_steps  (rsp_passed_steps)
);
